// ----- rtl/relu_neuron_train_engine_assert.svh -----
// Assertion macros used by the back-end module
`ifndef RELU_NEURON_TRAIN_ENGINE_ASSERT_SVH
`define RELU_NEURON_TRAIN_ENGINE_ASSERT_SVH

// a condition must hold at every edge out of reset
`define RNTE_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// a trigger must be followed in the next cycle by a consequence
`define RNTE_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rnte_pkg.sv -----
`default_nettype none
package rnte_pkg;
  localparam int KIND_W = 3;
  localparam int POS_W = 8;
  localparam int FIELD_W = 16;
  localparam int RATE_W = 16;
  localparam int ACC_W = 32;
  localparam int MAX_FAN_IN = 256;
  localparam int VALUE_WIDTH = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 3'd0,
    KIND_FWD  = 3'd1,
    KIND_BWD  = 3'd2,
    KIND_SETE = 3'd3,
    KIND_STEP = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RES_FWD  = 2'd0,
    RES_ERR  = 2'd1,
    RES_STEP = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_ISSUE,
    ST_MUL,
    ST_STEP
  } back_state_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t               kind;
    logic [POS_W-1:0]    position;
    logic [FIELD_W-1:0]  value;
    logic [FIELD_W-1:0]  weight_in;
    logic                last;
  } cmd_t;
endpackage
`default_nettype wire

// ----- rtl/rnte_front.sv -----
`default_nettype none
// Accepts input transfers, drops unknown kinds, queues commands for the back end.
module rnte_front #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rnte_pkg::cmd_t in_cmd,
  output logic               q_valid,
  input  wire logic          q_ready,
  output rnte_pkg::cmd_t     q_cmd
);
  localparam int PW = $clog2(DEPTH);
  rnte_pkg::cmd_t   mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      count;
  logic             known, push, pop;

  assign known = in_cmd.kind inside {rnte_pkg::KIND_LOAD, rnte_pkg::KIND_FWD,
                                     rnte_pkg::KIND_BWD, rnte_pkg::KIND_SETE,
                                     rnte_pkg::KIND_STEP};
  assign in_ready = (count != (PW+1)'(DEPTH));
  assign push = in_valid && in_ready && known;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rnte_back.sv -----
`default_nettype none
`include "relu_neuron_train_engine_assert.svh"
// Executes commands: weight memory, MAC, SGD step, result register.
module rnte_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [rnte_pkg::RATE_W-1:0] rate,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire rnte_pkg::cmd_t q_cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic [1:0]          res_kind,
  output logic [14:0]         res_out,
  output logic [15:0]         res_pre,
  output logic [15:0]         res_err
);
  localparam int AW = $clog2(rnte_pkg::MAX_FAN_IN);
  localparam int VW = rnte_pkg::VALUE_WIDTH;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW-1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  rnte_pkg::back_state_t state, state_next;
  logic [VW-1:0]            wmem [rnte_pkg::MAX_FAN_IN];
  logic [VW-1:0]            rd_w;
  rnte_pkg::cmd_t           cur;
  logic signed [31:0]       acc;
  logic signed [VW-1:0]     pre_st, err_st;
  logic signed [32:0]       prod;
  logic signed [31:0]       ev;
  logic signed [16:0]       rate_s;
  logic [AW-1:0]            addr;
  logic                     take, wr_en, fin, step_mul;
  logic [VW-1:0]            wr_data;
  logic signed [15:0]       val16, win16;
  logic signed [63:0]       accsum, sh, evr, d, nw;
  logic signed [VW-1:0]     sat_sum;

  assign val16 = $signed(q_cmd.value);
  assign win16 = $signed(q_cmd.weight_in);
  assign rate_s = $signed({1'b0, rate});
  assign addr = AW'(q_cmd.position);
  assign take = q_valid && q_ready;
  assign fin = (state == rnte_pkg::ST_MUL) && cur.last &&
               (cur.kind inside {rnte_pkg::KIND_FWD, rnte_pkg::KIND_BWD});
  assign step_mul = (state == rnte_pkg::ST_MUL) && (cur.kind == rnte_pkg::KIND_STEP);

  always_comb begin
    state_next = state;
    case (state)
      rnte_pkg::ST_ISSUE: begin
        if (take && (q_cmd.kind inside {rnte_pkg::KIND_FWD, rnte_pkg::KIND_BWD}))
          state_next = rnte_pkg::ST_MUL;
        else if (take && q_cmd.kind == rnte_pkg::KIND_STEP)
          state_next = rnte_pkg::ST_MUL;
      end
      rnte_pkg::ST_MUL:
        state_next = (cur.kind == rnte_pkg::KIND_STEP) ? rnte_pkg::ST_STEP : rnte_pkg::ST_ISSUE;
      rnte_pkg::ST_STEP: state_next = rnte_pkg::ST_ISSUE;
      default: state_next = rnte_pkg::ST_ISSUE;
    endcase
  end

  // an item is taken only in ST_ISSUE and once the result register is free or being read
  always_comb begin
    q_ready = (state == rnte_pkg::ST_ISSUE) && (!res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (take) rd_w <= wmem[addr];
    if (wr_en) wmem[cur.position[AW-1:0]] <= wr_data;
    else if (take && q_cmd.kind == rnte_pkg::KIND_LOAD) wmem[addr] <= VW'(val16);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_cmd;
      if (q_cmd.kind == rnte_pkg::KIND_BWD) prod <= 33'(win16 * val16);
      if (q_cmd.kind == rnte_pkg::KIND_STEP) ev <= err_st * val16;
    end
  end

  // forward multiply needs the registered weight, done combinationally in ST_MUL
  always_comb begin
    logic signed [31:0] p;
    p = (cur.kind == rnte_pkg::KIND_FWD) ? 32'($signed(rd_w) * $signed(cur.value)) :
                                           32'(prod);
    accsum = 64'(acc) + 64'(p);
    if (accsum > 64'sd2147483647) accsum = 64'sd2147483647;
    else if (accsum < -64'sd2147483648) accsum = -64'sd2147483648;
    sh = accsum >>> 8;
    if (sh > VMAX) sh = VMAX;
    else if (sh < VMIN) sh = VMIN;
    sat_sum = VW'(sh);
  end

  // error x input always fits 32 bits, so the rate product is 32 x 17
  always_ff @(posedge clk) begin
    if (step_mul) evr <= ev * rate_s;
  end

  always_comb begin
    d = (evr + (64'sd1 <<< 23)) >>> 24;
    nw = 64'($signed(rd_w)) - d;
    if (nw > VMAX) nw = VMAX;
    else if (nw < VMIN) nw = VMIN;
    wr_en = (state == rnte_pkg::ST_STEP);
    wr_data = VW'(nw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnte_pkg::ST_ISSUE;
      acc <= '0;
      pre_st <= '0;
      err_st <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (take && q_cmd.kind == rnte_pkg::KIND_SETE) err_st <= VW'(val16);
      if (state == rnte_pkg::ST_MUL && cur.kind != rnte_pkg::KIND_STEP) begin
        acc <= cur.last ? '0 : accsum[31:0];
        if (fin) begin
          res_valid <= 1'b1;
          if (cur.kind == rnte_pkg::KIND_FWD) begin
            pre_st <= sat_sum;
            res_kind <= rnte_pkg::RES_FWD;
            res_pre <= 16'(sat_sum);
            res_out <= (sat_sum > 0) ? 15'(sat_sum) : '0;
            res_err <= '0;
          end else begin
            err_st <= (pre_st > 0) ? sat_sum : '0;
            res_kind <= rnte_pkg::RES_ERR;
            res_pre <= '0;
            res_out <= '0;
            res_err <= (pre_st > 0) ? 16'(sat_sum) : '0;
          end
        end
      end
      if (wr_en && cur.last) begin
        res_valid <= 1'b1;
        res_kind <= rnte_pkg::RES_STEP;
        res_pre <= '0;
        res_out <= '0;
        res_err <= '0;
      end
    end
  end

  `RNTE_NEXT(a_step_wb, clk, rst, step_mul, state == rnte_pkg::ST_STEP, "step write-back late")
  `RNTE_ALWAYS(a_no_take_busy, clk, rst, !(take && state != rnte_pkg::ST_ISSUE), "taken busy")
  `RNTE_NEXT(a_fin_res, clk, rst, fin, res_valid, "finished sum gave no result")
endmodule
`default_nettype wire

// ----- rtl/relu_neuron_train_engine.sv -----
`default_nettype none
// One ReLU neuron with its own 256-entry weight memory and SGD update, Q8.8
// values and a 32-bit saturating accumulator. Input transfers are registered
// in a two-entry queue ahead of the back end; unknown kinds are dropped there.
// In the back end a load or set-error item is done at issue, a forward or
// backward item goes through memory read, then multiply-accumulate, and a
// step item through read and error product, rate product, weight write-back.
// The back end takes no item while a result waits, so a stalled output backs
// up the queue. A weight reads as undefined until it has been loaded.
module relu_neuron_train_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        learning_rate_we,
  input  wire logic [15:0] learning_rate_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // position[7:0], value[23:8], weight_in[39:24]
  input  wire logic [2:0]  s_axis_tuser,  // kind
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // output_value[14:0], pre_activation[30:15],
                                          // error_value[46:31], zero pad
  output logic [1:0]       m_axis_tuser   // result_kind
);
  logic [15:0]    rate;
  rnte_pkg::cmd_t in_cmd, q_cmd;
  logic           q_valid, q_ready;
  logic [14:0]    r_out;
  logic [15:0]    r_pre, r_err;

  always_ff @(posedge clk) begin
    if (rst) rate <= 16'd66;
    else if (learning_rate_we) rate <= learning_rate_wdata;
  end

  always_comb begin
    in_cmd.kind = rnte_pkg::kind_t'(s_axis_tuser);
    in_cmd.position = s_axis_tdata[7:0];
    in_cmd.value = s_axis_tdata[23:8];
    in_cmd.weight_in = s_axis_tdata[39:24];
    in_cmd.last = s_axis_tlast;
  end

  rnte_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  rnte_back u_back (
    .clk, .rst, .rate, .q_valid, .q_ready, .q_cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_kind(m_axis_tuser),
    .res_out(r_out), .res_pre(r_pre), .res_err(r_err)
  );

  assign m_axis_tdata = {1'b0, r_err, r_pre, r_out};
endmodule
`default_nettype wire
